// ===== hdl/hrvws_pkg.sv =====
`default_nettype none
package hrvws_pkg;
	localparam int RR_W = 16;
	localparam int RESP_W = 8;
	localparam int MEAN_W = 23;
	localparam int SDNN_W = 22;
	localparam int RMSSD_W = 23;
	localparam int PNN_W = 14;
	localparam logic [15:0] THRESH_RESET = 16'd50;
	localparam int SCALE = 100;
	localparam int SCALE_SQ = 10000;
	localparam int PCT_SCALE = 10000;

	typedef logic [RR_W-1:0] rr_t;
endpackage
`default_nettype wire

// ===== hdl/hrv_window_statistics_core.sv =====
// Time-domain heart rate variability over the last WINDOW RR intervals. Each input
// transfer on s_axis stores one interval; once WINDOW intervals are held, every
// transfer yields one m_axis result with max, min, 100x mean, 100x SDNN, 100x RMSSD
// and 100x pNN50 (exact floors) plus the respiration rate copied through. The window
// is a circular memory read back entry by entry, and the squares and the reciprocal
// divisions share one 32x32 multiplier while both roots use one integer square root
// unit, each worked one step per cycle under a small sequencer. The constant divisions
// are reciprocal multiplications built from four partial products on the shared
// multiplier. An interval that completes the window keeps s_axis_tready low while the
// sequencer squares each window entry and then its squared successive difference,
// forms the variance numerator, runs the 4 divisions and the 2 roots with sequencing
// between them, and loads the output register. A result waits in its output register
// until taken, and the next transfer is accepted alongside; a second result then
// waits in the sequencer, holding s_axis_tready low. Intervals that do not fill the
// window are stored while idle and give no result.
`default_nettype none
module hrv_window_statistics_core
	import hrvws_pkg::*;
#(
	parameter int WINDOW = 20
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// rr_interval[15:0], respiration_rate[23:16]
	input  wire logic [23:0] s_axis_tdata,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// max_interval[15:0], min_interval[31:16], mean_x100[54:32], sdnn_x100[76:55],
	// rmssd_x100[99:77], pnn50_x100[113:100], respiration_out[121:114], zeros above
	output logic [127:0]     m_axis_tdata
);
	localparam int AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CW = $clog2(WINDOW + 1);
	localparam logic [CW-1:0] WIN_C = CW'(WINDOW);
	localparam logic [63:0] W64 = 64'(WINDOW);
	localparam int DIV_N = 56;
	localparam int SH_W = DIV_N + $clog2(WINDOW);
	localparam int SH_SQ = DIV_N + $clog2(WINDOW * WINDOW);
	localparam int SH_M1 = DIV_N + $clog2(WINDOW - 1);
	localparam logic [63:0] RCP_W = 64'(((128'd1 << SH_W) / 128'(WINDOW)) + 128'd1);
	localparam logic [63:0] RCP_SQ =
		64'(((128'd1 << SH_SQ) / 128'(WINDOW * WINDOW)) + 128'd1);
	localparam logic [63:0] RCP_M1 = 64'(((128'd1 << SH_M1) / 128'(WINDOW - 1)) + 128'd1);

	localparam logic [3:0] ST_IDLE = 4'd0, ST_RD = 4'd1, ST_ACC = 4'd2, ST_M1 = 4'd3,
		ST_M2 = 4'd4, ST_DIV = 4'd5, ST_SQRT = 4'd6, ST_NEXT = 4'd7, ST_OUT = 4'd8;
	localparam logic [2:0] PH_MEAN = 3'd0, PH_VAR = 3'd1, PH_SDNN = 3'd2,
		PH_RMS = 3'd3, PH_RMSQ = 3'd4, PH_PNN = 3'd5;

	logic [3:0] state_q;
	logic [2:0] phase_q;
	logic [15:0] thresh_q;
	logic [CW-1:0] fill_q;
	logic [AW-1:0] head_q, rd_ptr_q;
	logic [CW-1:0] idx_q;
	rr_t mem_q [WINDOW];
	rr_t rd_data_q, prev_q, max_q, min_q;
	logic [7:0] resp_q;
	logic [31:0] sum_q;
	logic [39:0] sumsq_q, dsq_q;
	logic [6:0] cnt_q;
	logic first_q;
	logic [63:0] num_q;
	logic [127:0] acc_q;
	logic [1:0] step_q;
	logic [63:0] root_q, bit_q, sqn_q;
	logic [MEAN_W-1:0] mean_q;
	logic [SDNN_W-1:0] sdnn_q;
	logic [RMSSD_W-1:0] rmssd_q;
	logic [PNN_W-1:0] pnn_q;
	logic out_v_q;
	logic [127:0] out_q;

	logic [31:0] mul_a, mul_b;
	logic [63:0] mul_p;
	logic [127:0] pp;
	logic [63:0] recip, quo;
	logic [63:0] sq_try;
	rr_t diff;

	assign cfg_ready = 1'b1;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata = out_q;
	assign mul_p = 64'(mul_a) * 64'(mul_b);
	assign sq_try = root_q + bit_q;
	assign diff = (rd_data_q >= prev_q) ? rd_data_q - prev_q : prev_q - rd_data_q;

	always_comb begin
		case (phase_q)
			PH_VAR: begin
				recip = RCP_SQ;
				quo = 64'(acc_q[SH_SQ +: DIV_N]);
			end
			PH_RMS, PH_PNN: begin
				recip = RCP_M1;
				quo = 64'(acc_q[SH_M1 +: DIV_N]);
			end
			default: begin
				recip = RCP_W;
				quo = 64'(acc_q[SH_W +: DIV_N]);
			end
		endcase
	end

	always_comb begin
		mul_a = 32'(rd_data_q);
		mul_b = 32'(rd_data_q);
		pp = 128'(mul_p);
		case (state_q)
			ST_ACC: begin
				if (step_q[0]) begin
					mul_a = 32'(diff);
					mul_b = 32'(diff);
				end
			end
			ST_M1: begin
				mul_a = sum_q;
				mul_b = sum_q;
			end
			ST_DIV: begin
				case (step_q)
					2'd0: begin
						mul_a = num_q[31:0];
						mul_b = recip[31:0];
						pp = 128'(mul_p);
					end
					2'd1: begin
						mul_a = num_q[31:0];
						mul_b = recip[63:32];
						pp = 128'(mul_p) << 32;
					end
					2'd2: begin
						mul_a = num_q[63:32];
						mul_b = recip[31:0];
						pp = 128'(mul_p) << 32;
					end
					default: begin
						mul_a = num_q[63:32];
						mul_b = recip[63:32];
						pp = 128'(mul_p) << 64;
					end
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready)
			mem_q[head_q] <= s_axis_tdata[15:0];
		rd_data_q <= mem_q[rd_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_MEAN;
			thresh_q <= THRESH_RESET;
			fill_q <= '0;
			head_q <= '0;
			rd_ptr_q <= '0;
			idx_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				thresh_q <= cfg_data;
			if (m_axis_tvalid && m_axis_tready && state_q != ST_OUT)
				out_v_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						resp_q <= s_axis_tdata[23:16];
						head_q <= (head_q == AW'(WINDOW - 1)) ? '0 : head_q + 1'b1;
						rd_ptr_q <= (head_q == AW'(WINDOW - 1)) ? '0 : head_q + 1'b1;
						if (fill_q != WIN_C)
							fill_q <= fill_q + 1'b1;
						if (fill_q >= WIN_C - 1'b1)
							state_q <= ST_RD;
					end
				end
				ST_RD: begin
					idx_q <= '0;
					step_q <= '0;
					first_q <= 1'b1;
					sum_q <= '0;
					sumsq_q <= '0;
					dsq_q <= '0;
					cnt_q <= '0;
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (!step_q[0]) begin
						rd_ptr_q <= (rd_ptr_q == AW'(WINDOW - 1)) ? '0 : rd_ptr_q + 1'b1;
						sum_q <= sum_q + 32'(rd_data_q);
						sumsq_q <= sumsq_q + 40'(mul_p);
						if (first_q || rd_data_q > max_q)
							max_q <= rd_data_q;
						if (first_q || rd_data_q < min_q)
							min_q <= rd_data_q;
						step_q <= 2'd1;
					end else begin
						prev_q <= rd_data_q;
						if (!first_q) begin
							dsq_q <= dsq_q + 40'(mul_p);
							if (diff > thresh_q)
								cnt_q <= cnt_q + 1'b1;
						end
						first_q <= 1'b0;
						idx_q <= idx_q + 1'b1;
						step_q <= 2'd0;
						if (idx_q == WIN_C - 1'b1)
							state_q <= ST_M1;
					end
				end
				ST_M1: begin
					num_q <= 64'(sumsq_q) * W64 - mul_p;
					state_q <= ST_M2;
				end
				ST_M2: begin
					num_q <= 64'(SCALE_SQ) * num_q;
					phase_q <= PH_VAR;
					state_q <= ST_DIV;
					step_q <= '0;
					acc_q <= '0;
				end
				ST_DIV: begin
					acc_q <= acc_q + pp;
					step_q <= step_q + 1'b1;
					if (step_q == 2'd3)
						state_q <= ST_NEXT;
				end
				ST_SQRT: begin
					if (sqn_q >= sq_try) begin
						sqn_q <= sqn_q - sq_try;
						root_q <= (root_q >> 1) + bit_q;
					end else begin
						root_q <= root_q >> 1;
					end
					bit_q <= bit_q >> 2;
					if (bit_q == 64'd1)
						state_q <= ST_NEXT;
				end
				ST_NEXT: begin
					step_q <= '0;
					acc_q <= '0;
					root_q <= '0;
					bit_q <= 64'd1 << 62;
					case (phase_q)
						PH_VAR: begin
							sqn_q <= quo;
							phase_q <= PH_SDNN;
							state_q <= ST_SQRT;
						end
						PH_SDNN: begin
							sdnn_q <= root_q[SDNN_W-1:0];
							num_q <= 64'(SCALE_SQ) * 64'(dsq_q);
							phase_q <= PH_RMS;
							state_q <= ST_DIV;
						end
						PH_RMS: begin
							sqn_q <= quo;
							phase_q <= PH_RMSQ;
							state_q <= ST_SQRT;
						end
						PH_RMSQ: begin
							rmssd_q <= root_q[RMSSD_W-1:0];
							num_q <= 64'(PCT_SCALE) * 64'(cnt_q);
							phase_q <= PH_PNN;
							state_q <= ST_DIV;
						end
						PH_PNN: begin
							pnn_q <= quo[PNN_W-1:0];
							num_q <= 64'(SCALE) * 64'(sum_q);
							phase_q <= PH_MEAN;
							state_q <= ST_DIV;
						end
						default: begin
							mean_q <= quo[MEAN_W-1:0];
							state_q <= ST_OUT;
						end
					endcase
				end
				ST_OUT: begin
					if (!out_v_q || m_axis_tready) begin
						out_q <= {6'd0, resp_q, pnn_q, rmssd_q, sdnn_q, mean_q, min_q, max_q};
						out_v_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== dv/hrv_window_statistics_checker.sv =====
`default_nettype none
module hrv_window_statistics_checker
	import hrvws_pkg::*;
#(
	parameter int WINDOW = 20
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         cfg_valid,
	input  wire logic         cfg_ready,
	input  wire logic [15:0]  cfg_data,
	input  wire logic         s_axis_tvalid,
	input  wire logic         s_axis_tready,
	input  wire logic [23:0]  s_axis_tdata,
	input  wire logic         m_axis_tvalid,
	input  wire logic         m_axis_tready,
	input  wire logic [127:0] m_axis_tdata,
	output int                errors,
	output int                pending,
	output int                checked
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [RR_W-1:0]    max_iv;
		logic [RR_W-1:0]    min_iv;
		logic [MEAN_W-1:0]  mean;
		logic [SDNN_W-1:0]  sdnn;
		logic [RMSSD_W-1:0] rmssd;
		logic [PNN_W-1:0]   pnn;
		logic [RESP_W-1:0]  resp;
	} hrv_stats_t;

	rr_t        beats[WINDOW];
	int         beats_held;
	logic [15:0] threshold;
	hrv_stats_t stats_due[$];

	function automatic longint unsigned floor_sqrt(longint unsigned n);
		longint unsigned r;
		longint unsigned t;
		r = 0;
		for (int b = 31; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= n)
				r = t;
		end
		return r;
	endfunction

	task automatic report(string what, longint unsigned got, longint unsigned want);
		$display("mismatch %s: got %0d, expected %0d (result %0d)", what, got, want, checked);
		errors++;
	endtask

	task automatic take_beat(rr_t rr, logic [RESP_W-1:0] resp);
		longint unsigned s, q, dsq, cnt, w, x, a, d;
		hrv_stats_t e;
		if (beats_held >= WINDOW) begin
			for (int i = 0; i < WINDOW - 1; i++)
				beats[i] = beats[i+1];
			beats[WINDOW-1] = rr;
		end else begin
			beats[beats_held] = rr;
			beats_held++;
		end
		if (beats_held < WINDOW)
			return;
		w = WINDOW;
		s = 0; q = 0; dsq = 0; cnt = 0;
		e.max_iv = beats[0];
		e.min_iv = beats[0];
		for (int i = 0; i < WINDOW; i++) begin
			x = beats[i];
			if (beats[i] > e.max_iv) e.max_iv = beats[i];
			if (beats[i] < e.min_iv) e.min_iv = beats[i];
			s += x;
			q += x * x;
			if (i > 0) begin
				a = beats[i-1];
				d = (x >= a) ? x - a : a - x;
				dsq += d * d;
				if (d > threshold)
					cnt++;
			end
		end
		e.mean = MEAN_W'((100 * s) / w);
		e.sdnn = SDNN_W'(floor_sqrt((10000 * (w * q - s * s)) / (w * w)));
		e.rmssd = RMSSD_W'(floor_sqrt((10000 * dsq) / (w - 1)));
		e.pnn = PNN_W'((10000 * cnt) / (w - 1));
		e.resp = resp;
		stats_due.push_back(e);
	endtask

	always @(posedge clk or negedge arst_n) begin
		hrv_stats_t e;
		if (!arst_n) begin
			beats_held = 0;
			threshold = THRESH_RESET;
			stats_due.delete();
			errors = 0;
			checked = 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				threshold = cfg_data;
			if (m_axis_tvalid && m_axis_tready) begin
				if (stats_due.size() == 0) begin
					$display("unexpected result transfer: %h", m_axis_tdata);
					errors++;
				end else begin
					e = stats_due.pop_front();
					if (m_axis_tdata[15:0] !== e.max_iv)
						report("max", m_axis_tdata[15:0], e.max_iv);
					if (m_axis_tdata[31:16] !== e.min_iv)
						report("min", m_axis_tdata[31:16], e.min_iv);
					if (m_axis_tdata[54:32] !== e.mean)
						report("mean", m_axis_tdata[54:32], e.mean);
					if (m_axis_tdata[76:55] !== e.sdnn)
						report("sdnn", m_axis_tdata[76:55], e.sdnn);
					if (m_axis_tdata[99:77] !== e.rmssd)
						report("rmssd", m_axis_tdata[99:77], e.rmssd);
					if (m_axis_tdata[113:100] !== e.pnn)
						report("pnn50", m_axis_tdata[113:100], e.pnn);
					if (m_axis_tdata[121:114] !== e.resp)
						report("respiration", m_axis_tdata[121:114], e.resp);
					if (m_axis_tdata[127:122] !== 6'd0)
						report("padding", m_axis_tdata[127:122], 0);
					checked++;
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				take_beat(s_axis_tdata[15:0], s_axis_tdata[23:16]);
			pending <= stats_due.size();
		end
	end

	task automatic final_check();
		if (stats_due.size() != 0) begin
			$display("%0d expected results never arrived", stats_due.size());
			errors += stats_due.size();
		end
	endtask
endmodule
`default_nettype wire

// ===== dv/hrv_window_statistics_core_test.sv =====
`default_nettype none
module hrv_window_statistics_core_test
	import hrvws_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WINDOW = 20;

	logic         clk = 0;
	logic         arst_n = 0;
	logic         cfg_valid = 0;
	logic         cfg_ready;
	logic [15:0]  cfg_data = 0;
	logic         s_axis_tvalid = 0;
	logic         s_axis_tready;
	logic [23:0]  s_axis_tdata = 0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 0;
	logic [127:0] m_axis_tdata;
	int           errors, pending, checked;

	bit quiet = 0;
	bit long_hold_req = 0;
	bit long_hold_done = 0;
	int beats_sent = 0;
	int base_rr = 800;

	hrv_window_statistics_core #(.WINDOW(WINDOW)) dut (.*);

	hrv_window_statistics_checker #(.WINDOW(WINDOW)) chk (
		.clk, .arst_n, .cfg_valid, .cfg_ready, .cfg_data,
		.s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
		.m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
		.errors, .pending, .checked
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	initial begin
		#50ms;
		$display("FAILED: results differ");
		$finish;
	end

	// result side backpressure
	initial begin
		forever begin
			@(posedge clk);
			if (long_hold_req && !long_hold_done) begin
				m_axis_tready <= 0;
				repeat (4000) @(posedge clk);
				long_hold_done = 1;
				m_axis_tready <= 1;
			end else if (!quiet && arst_n && $urandom_range(0, 7) == 0) begin
				m_axis_tready <= 0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
				m_axis_tready <= 1;
			end else begin
				m_axis_tready <= arst_n;
			end
		end
	end

	task automatic send_beat(logic [15:0] rr, logic [7:0] resp);
		int gap;
		gap = (!quiet && $urandom_range(0, 5) == 0) ? $urandom_range(1, 18) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {resp, rr};
		do @(posedge clk); while (!s_axis_tready);
		beats_sent++;
	endtask

	task automatic drain();
		int n;
		s_axis_tvalid <= 0;
		@(posedge clk);
		n = 0;
		while (pending != 0 && n < 200000) begin
			@(posedge clk);
			n++;
		end
		repeat (700) @(posedge clk);
	endtask

	task automatic write_threshold(logic [15:0] v);
		cfg_valid <= 1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		@(posedge clk);
	endtask

	task automatic random_beats(int count, logic [15:0] thr);
		int rr, step;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 9))
				0: rr = $urandom_range(0, 65535);
				1: rr = $urandom_range(0, 1) ? 65535 : 0;
				2: begin
					// steps right at the pnn50 threshold
					step = $urandom_range(0, 1) ? thr : thr + 1;
					rr = $urandom_range(0, 1) ? base_rr + step : base_rr - step;
				end
				default: begin
					base_rr += $urandom_range(0, 40) - 20;
					if (base_rr < 300) base_rr = 300;
					if (base_rr > 2000) base_rr = 2000;
					rr = base_rr + $urandom_range(0, 160) - 80;
				end
			endcase
			if (rr < 0) rr = 0;
			if (rr > 65535) rr = 65535;
			if (long_hold_req == 0 && thr != 50 && i == 50)
				long_hold_req = 1;
			send_beat(rr[15:0], 8'($urandom_range(0, 255)));
		end
	endtask

	initial begin
		logic [15:0] rr;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: extremes first, then steps around the default threshold
		for (int i = 0; i < 24; i++) begin
			if (i < 10)
				rr = (i % 2) ? 16'hffff : 16'h0000;
			else if (i < 20)
				rr = 16'd1000 + ((i % 2) ? 16'd50 : 16'd0) + ((i % 4 == 3) ? 16'd1 : 16'd0);
			else
				rr = 16'hffff;
			send_beat(rr, (i % 3 == 0) ? 8'd0 : (i % 3 == 1) ? 8'd255 : i[7:0]);
		end
		drain();
		write_threshold(16'd0);
		random_beats(350, 16'd0);
		drain();
		write_threshold(16'hffff);
		random_beats(350, 16'hffff);
		drain();
		rr = 16'($urandom_range(1, 400));
		write_threshold(rr);
		random_beats(350, rr);
		drain();
		write_threshold(THRESH_RESET);
		quiet = 1;
		random_beats(330, THRESH_RESET);
		drain();
		chk.final_check();
		$display("sent %0d intervals over thresholds 50, 0, 65535, %0d, 50", beats_sent, rr);
		$display("compared %0d statistics results, %0d mismatches", checked, errors);
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule
`default_nettype wire
